@@ hw/rtl/rarsf_pkg.sv @@
// Shared types, widths and helper functions for the range-add / range-sum
// Fenwick tree block. No dependencies.
package rarsf_pkg;

  // Capacity of the trees; entries 1..MAX_ENTRIES are used, entry 0 is spare
  localparam int MAX_ENTRIES = 1024;
  localparam int DEPTH       = MAX_ENTRIES + 1;

  // Field widths fixed by the interface
  localparam int ACT_W = 2;
  localparam int IDX_W = 11;
  localparam int VAL_W = 64;

  // Tree address, walk index (may step past the end once) and compare widths
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int WALK_W = ADDR_W + 1;
  localparam int CMP_W  = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;

  localparam logic [IDX_W-1:0] SIZE_RESET = IDX_W'(1024);

  // Action codes
  localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ADD  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SUM  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_WALK,
    ST_MUL,
    ST_SUB,
    ST_OUT
  } state_t;

  // Clamp the programmed size into 1..MAX_ENTRIES
  function automatic logic [ADDR_W-1:0] eff_size(input logic [IDX_W-1:0] s);
    logic [ADDR_W-1:0] r;
    if (s == '0) begin
      r = ADDR_W'(1);
    end else if (CMP_W'(s) > CMP_W'(MAX_ENTRIES)) begin
      r = ADDR_W'(MAX_ENTRIES);
    end else begin
      r = ADDR_W'(s);
    end
    return r;
  endfunction

  // Lowest set bit of a walk index
  function automatic logic [WALK_W-1:0] low_bit(input logic [WALK_W-1:0] x);
    return x & (~x + WALK_W'(1));
  endfunction

endpackage

@@ hw/rtl/rarsf_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Read-first on a same-address collision. No dependencies.
module rarsf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/range_add_range_sum_fenwick.sv @@
// Range-add / range-sum engine on two Fenwick trees (plain differences and
// index-weighted differences), each held in its own 64-bit RAM with a
// registered read; depends on rarsf_pkg and rarsf_ram. After reset a
// clearing pass writes zero to all MAX_ENTRIES+1 entries while in_ready
// stays low; cfg writes are taken at any time. One item is handled at a
// time. Each tree walk reads one entry per cycle, and an update walk writes
// each updated value back the next cycle; a walk touches at most log2(size)+1
// entries. A load takes one update walk, a range add two, a range sum two
// prefix walks plus a multiply and a subtract each; a flagged or empty query
// skips the walks. A query result may wait in ST_OUT for out_ready.
// Loads, adds and unused actions give no result; a query with an index
// outside 1..size gives zero with index_error set. The result sits in an
// output register, so a new item is taken while it waits for out_ready.
module range_add_range_sum_fenwick (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [rarsf_pkg::IDX_W-1:0]    cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rarsf_pkg::ACT_W-1:0]    in_action,
  input  logic [rarsf_pkg::IDX_W-1:0]    in_left_index,
  input  logic [rarsf_pkg::IDX_W-1:0]    in_right_index,
  input  logic signed [rarsf_pkg::VAL_W-1:0] in_operand_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [rarsf_pkg::VAL_W-1:0] out_range_sum,
  output logic                           out_index_error
);

  import rarsf_pkg::*;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r;
  logic [IDX_W-1:0]    cfg_size_r;
  logic [VAL_W-1:0]    last_r;
  logic                up_r;
  logic                is_add_r;
  logic                walk2_r;
  logic [WALK_W-1:0]   idx_r;
  logic [ADDR_W-1:0]   lim_r;
  logic [ADDR_W-1:0]   fac_r;
  logic [ADDR_W-1:0]   lm1_r;
  logic [ADDR_W-1:0]   rgt_r;
  logic [VAL_W-1:0]    val_r;
  logic [VAL_W-1:0]    dplain_r;
  logic [VAL_W-1:0]    dweight_r;
  logic [VAL_W-1:0]    acc_p_r;
  logic [VAL_W-1:0]    acc_w_r;
  logic [VAL_W-1:0]    prod_r;
  logic [VAL_W-1:0]    sum_r;
  logic                err_r;
  logic                rv_r;
  logic [ADDR_W-1:0]   ra_r;
  logic                out_valid_r;
  logic [VAL_W-1:0]    out_sum_r;
  logic                out_err_r;

  logic [ADDR_W-1:0]   size_n;
  logic                left_ok, right_ok, ordered;
  logic                step_ok;
  logic [ADDR_W-1:0]   prep_fac;
  logic [VAL_W-1:0]    mul_a;
  logic [ADDR_W-1:0]   mul_b;
  logic [VAL_W-1:0]    mul_y;
  logic                rd_en, wr_en, out_load;
  logic [ADDR_W-1:0]   rd_addr, wr_addr;
  logic [VAL_W-1:0]    wr_p, wr_w, rd_p, rd_w;

  // Decode the offered item against the clamped size
  assign size_n   = eff_size(cfg_size_r);
  assign left_ok  = (in_left_index != '0) && (CMP_W'(in_left_index) <= CMP_W'(size_n));
  assign right_ok = (in_right_index != '0) && (CMP_W'(in_right_index) <= CMP_W'(size_n));
  assign ordered  = (in_left_index <= in_right_index);

  // Walk continues while the index is inside the tree
  assign step_ok = up_r ? ((idx_r != '0) && (idx_r <= WALK_W'(lim_r))) : (idx_r != '0);

  // One shared multiplier: update weights in PREP, p * S1 in MUL
  assign prep_fac = walk2_r ? rgt_r : lm1_r;
  assign mul_a    = (state_r == ST_PREP) ? dplain_r : acc_p_r;
  assign mul_b    = (state_r == ST_PREP) ? prep_fac : fac_r;
  assign mul_y    = mul_a * VAL_W'(mul_b);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_cnt_r == ADDR_W'(MAX_ENTRIES)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_action)
            ACT_LOAD: if (left_ok) state_nxt = ST_PREP;
            ACT_ADD:  if (left_ok && right_ok && ordered) state_nxt = ST_PREP;
            ACT_SUM: begin
              if (!left_ok || !right_ok || !ordered) state_nxt = ST_OUT;
              else state_nxt = ST_WALK;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PREP: state_nxt = ST_WALK;
      ST_WALK: begin
        if (!step_ok) begin
          if (!up_r) state_nxt = ST_MUL;
          else if (is_add_r && !walk2_r) state_nxt = ST_PREP;
          else state_nxt = ST_IDLE;
        end
      end
      ST_MUL: state_nxt = ST_SUB;
      ST_SUB: state_nxt = walk2_r ? ST_OUT : ST_WALK;
      ST_OUT: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs and memory ports
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    rd_en    = (state_r == ST_WALK) && step_ok;
    rd_addr  = idx_r[ADDR_W-1:0];
    out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_p    = '0;
      wr_w    = '0;
    end else begin
      wr_en   = rv_r && up_r;
      wr_addr = ra_r;
      wr_p    = rd_p + dplain_r;
      wr_w    = rd_w + dweight_r;
    end
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      cfg_size_r  <= SIZE_RESET;
      last_r      <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      if (cfg_wr_en) cfg_size_r <= cfg_wr_data;
      if (in_valid && in_ready && (in_action == ACT_LOAD) && left_ok) begin
        last_r <= in_operand_value;
      end
      rv_r <= rd_en;
      // Hold the result until the transfer completes
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    ra_r <= rd_addr;
    if (out_load) begin
      out_sum_r <= sum_r;
      out_err_r <= err_r;
    end
    // Accumulate returned tree entries; the second prefix walk subtracts
    if (rv_r && !up_r) begin
      acc_p_r <= walk2_r ? (acc_p_r - rd_p) : (acc_p_r + rd_p);
      acc_w_r <= walk2_r ? (acc_w_r - rd_w) : (acc_w_r + rd_w);
    end
    unique case (state_r)
      ST_IDLE: begin
        lm1_r    <= ADDR_W'(in_left_index - IDX_W'(1));
        rgt_r    <= ADDR_W'(in_right_index);
        lim_r    <= size_n;
        val_r    <= in_operand_value;
        is_add_r <= (in_action == ACT_ADD);
        up_r     <= (in_action != ACT_SUM);
        walk2_r  <= 1'b0;
        acc_p_r  <= '0;
        acc_w_r  <= '0;
        sum_r    <= '0;
        err_r    <= !left_ok || !right_ok;
        idx_r    <= WALK_W'(in_right_index);
        fac_r    <= ADDR_W'(in_right_index);
        dplain_r <= (in_action == ACT_LOAD) ? (in_operand_value - last_r) : in_operand_value;
      end
      ST_PREP: begin
        dweight_r <= mul_y;
        idx_r     <= WALK_W'(prep_fac) + WALK_W'(1);
      end
      ST_WALK: begin
        if (step_ok) begin
          idx_r <= up_r ? (idx_r + low_bit(idx_r)) : (idx_r - low_bit(idx_r));
        end else if (up_r) begin
          // Second walk of a range add removes the addend past the right end
          walk2_r  <= 1'b1;
          dplain_r <= '0 - val_r;
        end
      end
      ST_MUL: prod_r <= mul_y;
      ST_SUB: begin
        sum_r <= sum_r + prod_r - acc_w_r;
        if (!walk2_r) begin
          walk2_r <= 1'b1;
          acc_p_r <= '0;
          acc_w_r <= '0;
          idx_r   <= WALK_W'(lm1_r);
          fac_r   <= lm1_r;
        end
      end
      ST_CLEAR, ST_OUT: ;
      default: ;
    endcase
  end

  // Tree memories
  rarsf_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_plain_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_p),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_p)
  );

  rarsf_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_weight_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_w),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_w)
  );

  assign out_valid       = out_valid_r;
  assign out_range_sum   = out_sum_r;
  assign out_index_error = out_err_r;

  // Write-back never lands on the entry read in the same cycle
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("tree read and write-back hit the same entry");

  // Walk reads stay inside the populated tree
  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> ((idx_r != '0) && (idx_r <= WALK_W'(MAX_ENTRIES))))
    else $error("tree walk index out of range");

  // Flagged queries report a zero sum
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_index_error) |-> (out_range_sum == '0))
    else $error("index error with nonzero sum");

endmodule
